/* design/cte_pkg.sv */
// Shared constants, types and the self-term coefficient for the edge orbit exponent block.
`default_nettype none

package cte_pkg;

  // sizing
  localparam int MAX_PAIRS  = 16;
  localparam int MAX_TOTAL  = 64;
  localparam int IDX_W      = $clog2(MAX_PAIRS);
  localparam int HELD_W     = $clog2(MAX_PAIRS + 1);

  // field widths
  localparam int LEN_W      = 7;
  localparam int MODE_W     = 4;
  localparam int MAXE_W     = 20;
  localparam int EXP_W      = 21;
  localparam int TOT_W      = 21;
  localparam int CNT_W      = 13;
  localparam int SELF_W     = 16;
  localparam int PROD2_W    = 2 * LEN_W;
  localparam int TERM_W     = 3 * LEN_W;
  localparam int CROSS_W    = TERM_W + HELD_W;
  localparam int SUM_W      = CROSS_W + 1;
  localparam int VSUM_W     = PROD2_W + 1;
  localparam int COEF_W     = LEN_W + 1;
  localparam int SHIFT_W    = $clog2(LEN_W);
  localparam int EACC_W     = TOT_W + 5;

  // shared multiplier
  localparam int MUL_A_W    = PROD2_W + 1;
  localparam int MUL_B_W    = COEF_W + 1;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

  // port widths
  localparam int IN_DATA_W  = ((2 * LEN_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((EXP_W + 7) / 8) * 8;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [TOT_W-1:0] TOT_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // register index, taken from paddr bit 2
  localparam logic REG_MODE    = 1'b0;
  localparam logic REG_MAX_EXP = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_TOURNAMENT = 4'd0,
    MODE_DIGRAPH    = 4'd1,
    MODE_RELATION   = 4'd2,
    MODE_GRAPH      = 4'd3,
    MODE_SYM_REL    = 4'd4,
    MODE_ORIENTED   = 4'd5,
    MODE_SC_TOURN   = 4'd6,
    MODE_SC_GRAPH   = 4'd7,
    MODE_A003086    = 4'd8,
    MODE_A005639    = 4'd9,
    MODE_A002499    = 4'd10,
    MODE_A002854    = 4'd11
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SAME1,
    ST_SAME2,
    ST_VERT,
    ST_SELF,
    ST_RD,
    ST_LOAD,
    ST_GCD,
    ST_MUL2,
    ST_ACC,
    ST_FIN
  } state_t;

  // per-cycle coefficient of the self term; the term is m times this
  function automatic logic signed [COEF_W-1:0] self_coef(input logic [MODE_W-1:0] md,
                                                         input logic [LEN_W-1:0]  r);
    logic [COEF_W-1:0] half;
    logic [COEF_W-1:0] quart;
    logic [COEF_W-1:0] odd_half;
    logic              even;
    half     = COEF_W'(r >> 1);
    quart    = (r >= LEN_W'(2)) ? COEF_W'((r - LEN_W'(2)) >> 2) : '0;
    odd_half = (r == '0) ? '0 : COEF_W'((r - LEN_W'(1)) >> 1);
    even     = ~r[0];
    case (md)
      MODE_TOURNAMENT, MODE_GRAPH: self_coef = $signed(half);
      MODE_SYM_REL:  self_coef = $signed(half + COEF_W'(1));
      MODE_ORIENTED: self_coef = $signed(odd_half);
      MODE_A005639:  self_coef = even ? $signed((quart << 1) + COEF_W'(1)) : '0;
      MODE_A002499:  self_coef = even ? $signed(half + (quart << 1) + COEF_W'(1))
                                      : $signed(half);
      MODE_A002854:  self_coef = $signed(half - COEF_W'(1));
      default:       self_coef = '0;
    endcase
  endfunction

endpackage

`default_nettype wire

/* design/cte_ram.sv */
// Generic single-port-write, registered-read RAM.
`default_nettype none

module cte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/cte_gcd.sv */
// Binary gcd unit, one reduction step per cycle.
`default_nettype none

module cte_gcd (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [cte_pkg::LEN_W-1:0] a_in,
  input  wire logic [cte_pkg::LEN_W-1:0] b_in,
  output logic                           done,
  output logic      [cte_pkg::LEN_W-1:0] g
);

  import cte_pkg::*;

  logic               busy_r,  busy_nxt;
  logic               done_r,  done_nxt;
  logic [LEN_W-1:0]   a_r,     a_nxt;
  logic [LEN_W-1:0]   b_r,     b_nxt;
  logic [SHIFT_W-1:0] k_r,     k_nxt;
  logic [LEN_W-1:0]   g_r,     g_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    k_r <= k_nxt;
    g_r <= g_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    a_nxt    = a_r;
    b_nxt    = b_r;
    k_nxt    = k_r;
    g_nxt    = g_r;
    if (start) begin
      a_nxt    = a_in;
      b_nxt    = b_in;
      k_nxt    = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (a_r == '0) begin
        // gcd(0,x) = x
        g_nxt    = LEN_W'(b_r << k_r);
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if (b_r == '0) begin
        g_nxt    = LEN_W'(a_r << k_r);
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if (!a_r[0] && !b_r[0]) begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + SHIFT_W'(1);
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_r >= b_r) begin
        a_nxt = (a_r - b_r) >> 1;
      end else begin
        b_nxt = (b_r - a_r) >> 1;
      end
    end
  end

  assign done = done_r;
  assign g    = g_r;

endmodule

`default_nettype wire

/* design/cycle_type_orbit_exponent.sv */
// Top level: edge orbit exponent of a permutation cycle type.
// Usage:
//  - in_*: one word per (cycle length, multiplicity) pair; tdata[6:0] length,
//    tdata[13:7] multiplicity, tlast marks the final pair of a cycle type.
//  - out_*: one word per cycle type, after its last pair; tdata[20:0] is the
//    signed exponent, tuser flags a result that is negative, above
//    max_exponent, from an unused mode, or from a run that saturated,
//    exceeded the vertex limit or held too many pairs.
//  - cfg_*: APB registers, mode at 0x0 and max_exponent at 0x4; write only
//    while idle. pready is tied high.
// Flow: one pair at a time, in_tready low while it is worked on. A pair
//  forms its own products first, then, for each pair already held, a RAM read,
//  a binary gcd and a multiply. The last pair then passes through a final
//  state that forms the result. One multiplier is shared by every product
//  in the sequence.
// Reset clears all totals, the pair count and the output register; the pair
//  store itself is not cleared, only entries below the count are read.
// A result waits in the output register while out_tready is low; the next
//  pairs are still taken, and a following last pair waits until the register
//  is free.
`default_nettype none

module cycle_type_orbit_exponent (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // pair stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [cte_pkg::IN_DATA_W-1:0]       in_tdata,   // cycle_length, multiplicity
  input  wire logic                                in_tlast,
  // result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [cte_pkg::OUT_DATA_W-1:0]      out_tdata,  // exponent
  output logic                                     out_tuser,  // out_of_range
  // register port
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [cte_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  wire logic [cte_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic      [cte_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                     cfg_pready
);

  import cte_pkg::*;

  localparam logic signed [EACC_W-1:0] E_HI = EACC_W'(2 ** (EXP_W - 1) - 1);
  localparam logic signed [EACC_W-1:0] E_LO = -EACC_W'(2 ** (EXP_W - 1));

  state_t state_r, state_nxt;

  // configuration
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [MAXE_W-1:0] maxe_r, maxe_nxt;

  // run totals
  logic [HELD_W-1:0]        held_r,     held_nxt;
  logic [TOT_W-1:0]         gtot_r,     gtot_nxt;
  logic [TOT_W-1:0]         getot_r,    getot_nxt;
  logic [CNT_W-1:0]         vtot_r,     vtot_nxt;
  logic [CNT_W-1:0]         ctot_r,     ctot_nxt;
  logic signed [SELF_W-1:0] stot_r,     stot_nxt;
  logic                     odd_r,      odd_nxt;
  logic                     ovf_r,      ovf_nxt;

  // current pair
  logic [LEN_W-1:0]         r_r,        r_nxt;
  logic [LEN_W-1:0]         m_r,        m_nxt;
  logic                     last_r,     last_nxt;
  logic signed [COEF_W-1:0] coef_r,     coef_nxt;
  logic [HELD_W-1:0]        idx_r,      idx_nxt;
  logic [PROD2_W-1:0]       tmp_r,      tmp_nxt;
  logic [TERM_W-1:0]        same_r,     same_nxt;
  logic [PROD2_W-1:0]       vprod_r,    vprod_nxt;
  logic signed [SELF_W-1:0] term_r,     term_nxt;
  logic [CROSS_W-1:0]       cross_r,    cross_nxt;
  logic [CROSS_W-1:0]       crosse_r,   crosse_nxt;
  logic                     ehit_r,     ehit_nxt;

  // output register
  logic                     oval_r,     oval_nxt;
  logic [EXP_W-1:0]         oexp_r,     oexp_nxt;
  logic                     oflag_r,    oflag_nxt;

  // shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  // pair store and gcd unit
  logic                     ram_we;
  logic [PROD2_W-1:0]       ram_rdata;
  logic [LEN_W-1:0]         rd_len;
  logic [LEN_W-1:0]         rd_cnt;
  logic                     gcd_start;
  logic                     gcd_done;
  logic [LEN_W-1:0]         gcd_g;

  logic                     cfg_wr;
  logic [LEN_W-1:0]         m_dec;

  // accumulate step
  logic [SUM_W-1:0]         gsum;
  logic [SUM_W-1:0]         gesum;
  logic                     gsat;
  logic                     gesat;
  logic [VSUM_W-1:0]        vsum;
  logic                     vsat;
  logic [CNT_W-1:0]         vnew;
  logic [CNT_W:0]           csum;
  logic                     csat;
  logic signed [SELF_W:0]   ssum;
  logic                     s_hi;
  logic                     s_lo;
  logic                     held_full;

  // final formula
  logic signed [EACC_W-1:0] g_s;
  logic signed [EACC_W-1:0] ge_s;
  logic signed [EACC_W-1:0] v_s;
  logic signed [EACC_W-1:0] n_s;
  logic signed [EACC_W-1:0] s_s;
  logic signed [EACC_W-1:0] odd_s;
  logic signed [EACC_W-1:0] maxe_s;
  logic signed [EACC_W-1:0] e_val;
  logic                     bad_mode;
  logic                     e_flag;
  logic [EXP_W-1:0]         e_sat;

  cte_ram #(
    .WIDTH (PROD2_W),
    .DEPTH (MAX_PAIRS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (held_r[IDX_W-1:0]),
    .wdata ({m_r, r_r}),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  cte_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .a_in  (r_r),
    .b_in  (rd_len),
    .done  (gcd_done),
    .g     (gcd_g)
  );

  assign rd_len = ram_rdata[LEN_W-1:0];
  assign rd_cnt = ram_rdata[PROD2_W-1:LEN_W];
  assign mul_p  = mul_a * mul_b;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign m_dec  = (m_r == '0) ? '0 : m_r - LEN_W'(1);

  // multiplier operands, chosen by sequencer state
  always_comb begin
    case (state_r)
      ST_SAME1: begin
        // m*(m-1)
        mul_a = $signed({{(MUL_A_W-LEN_W){1'b0}}, m_r});
        mul_b = $signed({{(MUL_B_W-LEN_W){1'b0}}, m_dec});
      end
      ST_SAME2: begin
        // C(m,2)*r
        mul_a = $signed({1'b0, tmp_r >> 1});
        mul_b = $signed({{(MUL_B_W-LEN_W){1'b0}}, r_r});
      end
      ST_VERT: begin
        mul_a = $signed({{(MUL_A_W-LEN_W){1'b0}}, r_r});
        mul_b = $signed({{(MUL_B_W-LEN_W){1'b0}}, m_r});
      end
      ST_SELF: begin
        mul_a = $signed({{(MUL_A_W-LEN_W){1'b0}}, m_r});
        mul_b = {coef_r[COEF_W-1], coef_r};
      end
      ST_LOAD: begin
        // m*m_j as the gcd is started
        mul_a = $signed({{(MUL_A_W-LEN_W){1'b0}}, m_r});
        mul_b = $signed({{(MUL_B_W-LEN_W){1'b0}}, rd_cnt});
      end
      ST_MUL2: begin
        mul_a = $signed({1'b0, tmp_r});
        mul_b = $signed({{(MUL_B_W-LEN_W){1'b0}}, gcd_g});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // saturating updates of the totals
  assign gsum  = SUM_W'(same_r) + SUM_W'(cross_r) + SUM_W'(gtot_r);
  assign gesum = SUM_W'(r_r[0] ? '0 : same_r) + SUM_W'(crosse_r) + SUM_W'(getot_r);
  assign gsat  = gsum > SUM_W'(TOT_MAX);
  assign gesat = gesum > SUM_W'(TOT_MAX);
  assign vsum  = VSUM_W'(vtot_r) + VSUM_W'(vprod_r);
  assign vsat  = vsum > VSUM_W'(CNT_MAX);
  assign vnew  = vsat ? CNT_MAX : vsum[CNT_W-1:0];
  assign csum  = (CNT_W+1)'(ctot_r) + (CNT_W+1)'(m_r);
  assign csat  = csum > (CNT_W+1)'(CNT_MAX);
  assign ssum  = {stot_r[SELF_W-1], stot_r} + {term_r[SELF_W-1], term_r};
  assign s_hi  = (ssum[SELF_W:SELF_W-1] == 2'b01);
  assign s_lo  = (ssum[SELF_W:SELF_W-1] == 2'b10);
  assign held_full = !(held_r < HELD_W'(MAX_PAIRS));

  // final formula, all terms widened to a common signed width
  assign g_s    = $signed(EACC_W'(gtot_r));
  assign ge_s   = $signed(EACC_W'(getot_r));
  assign v_s    = $signed(EACC_W'(vtot_r));
  assign n_s    = $signed(EACC_W'(ctot_r));
  assign s_s    = EACC_W'(stot_r);
  assign odd_s  = $signed(EACC_W'(odd_r));
  assign maxe_s = $signed(EACC_W'(maxe_r));

  always_comb begin
    bad_mode = 1'b0;
    case (mode_r)
      MODE_TOURNAMENT, MODE_GRAPH, MODE_SYM_REL, MODE_ORIENTED:
                      e_val = g_s + s_s;
      MODE_DIGRAPH:   e_val = (g_s <<< 1) + v_s - n_s;
      MODE_RELATION, MODE_SC_TOURN:
                      e_val = (g_s <<< 1) + v_s;
      MODE_SC_GRAPH:  e_val = (g_s <<< 2) + (v_s <<< 1);
      MODE_A003086:   e_val = (g_s <<< 2) + (v_s <<< 1) - n_s;
      MODE_A005639:   e_val = ge_s + s_s;
      MODE_A002499:   e_val = g_s + ge_s + s_s;
      MODE_A002854:   e_val = g_s + s_s + odd_s;
      default: begin
        e_val    = '0;
        bad_mode = 1'b1;
      end
    endcase
  end

  assign e_flag = ovf_r || bad_mode || (e_val < 0) || (e_val > maxe_s);
  assign e_sat  = (e_val > E_HI) ? E_HI[EXP_W-1:0] :
                  (e_val < E_LO) ? E_LO[EXP_W-1:0] : e_val[EXP_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_TOURNAMENT;
      maxe_r  <= '1;
      held_r  <= '0;
      gtot_r  <= '0;
      getot_r <= '0;
      vtot_r  <= '0;
      ctot_r  <= '0;
      stot_r  <= '0;
      odd_r   <= 1'b0;
      ovf_r   <= 1'b0;
      idx_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      maxe_r  <= maxe_nxt;
      held_r  <= held_nxt;
      gtot_r  <= gtot_nxt;
      getot_r <= getot_nxt;
      vtot_r  <= vtot_nxt;
      ctot_r  <= ctot_nxt;
      stot_r  <= stot_nxt;
      odd_r   <= odd_nxt;
      ovf_r   <= ovf_nxt;
      idx_r   <= idx_nxt;
      oval_r  <= oval_nxt;
    end
    r_r      <= r_nxt;
    m_r      <= m_nxt;
    last_r   <= last_nxt;
    coef_r   <= coef_nxt;
    tmp_r    <= tmp_nxt;
    same_r   <= same_nxt;
    vprod_r  <= vprod_nxt;
    term_r   <= term_nxt;
    cross_r  <= cross_nxt;
    crosse_r <= crosse_nxt;
    ehit_r   <= ehit_nxt;
    oexp_r   <= oexp_nxt;
    oflag_r  <= oflag_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    maxe_nxt   = maxe_r;
    held_nxt   = held_r;
    gtot_nxt   = gtot_r;
    getot_nxt  = getot_r;
    vtot_nxt   = vtot_r;
    ctot_nxt   = ctot_r;
    stot_nxt   = stot_r;
    odd_nxt    = odd_r;
    ovf_nxt    = ovf_r;
    r_nxt      = r_r;
    m_nxt      = m_r;
    last_nxt   = last_r;
    coef_nxt   = coef_r;
    idx_nxt    = idx_r;
    tmp_nxt    = tmp_r;
    same_nxt   = same_r;
    vprod_nxt  = vprod_r;
    term_nxt   = term_r;
    cross_nxt  = cross_r;
    crosse_nxt = crosse_r;
    ehit_nxt   = ehit_r;
    oval_nxt   = oval_r && !out_tready;
    oexp_nxt   = oexp_r;
    oflag_nxt  = oflag_r;
    ram_we     = 1'b0;
    gcd_start  = 1'b0;

    if (cfg_wr) begin
      if (cfg_paddr[2] == REG_MAX_EXP) begin
        maxe_nxt = cfg_pwdata[MAXE_W-1:0];
      end else begin
        mode_nxt = cfg_pwdata[MODE_W-1:0];
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          r_nxt      = in_tdata[LEN_W-1:0];
          m_nxt      = in_tdata[2*LEN_W-1:LEN_W];
          last_nxt   = in_tlast;
          // self term follows the mode in force when the pair arrives
          coef_nxt   = self_coef(mode_r, in_tdata[LEN_W-1:0]);
          idx_nxt    = '0;
          cross_nxt  = '0;
          crosse_nxt = '0;
          state_nxt  = ST_SAME1;
        end
      end
      ST_SAME1: begin
        tmp_nxt   = mul_p[PROD2_W-1:0];
        state_nxt = ST_SAME2;
      end
      ST_SAME2: begin
        same_nxt  = mul_p[TERM_W-1:0];
        state_nxt = ST_VERT;
      end
      ST_VERT: begin
        vprod_nxt = mul_p[PROD2_W-1:0];
        state_nxt = ST_SELF;
      end
      ST_SELF: begin
        term_nxt  = mul_p[SELF_W-1:0];
        state_nxt = ST_RD;
      end
      ST_RD: begin
        // store read address is idx_r; data lands next cycle
        if (idx_r < held_r) begin
          state_nxt = ST_LOAD;
        end else begin
          state_nxt = ST_ACC;
        end
      end
      ST_LOAD: begin
        gcd_start = 1'b1;
        ehit_nxt  = !r_r[0] || !rd_len[0];
        tmp_nxt   = mul_p[PROD2_W-1:0];
        state_nxt = ST_GCD;
      end
      ST_GCD: begin
        if (gcd_done) begin
          state_nxt = ST_MUL2;
        end
      end
      ST_MUL2: begin
        cross_nxt = cross_r + CROSS_W'(mul_p[TERM_W-1:0]);
        if (ehit_r) begin
          crosse_nxt = crosse_r + CROSS_W'(mul_p[TERM_W-1:0]);
        end
        idx_nxt   = idx_r + HELD_W'(1);
        state_nxt = ST_RD;
      end
      ST_ACC: begin
        gtot_nxt  = gsat  ? TOT_MAX : gsum[TOT_W-1:0];
        getot_nxt = gesat ? TOT_MAX : gesum[TOT_W-1:0];
        vtot_nxt  = vnew;
        ctot_nxt  = csat ? CNT_MAX : csum[CNT_W-1:0];
        stot_nxt  = s_hi ? {1'b0, {(SELF_W-1){1'b1}}} :
                    s_lo ? {1'b1, {(SELF_W-1){1'b0}}} : ssum[SELF_W-1:0];
        odd_nxt   = odd_r || r_r[0];
        ovf_nxt   = ovf_r || gsat || gesat || vsat || csat || s_hi || s_lo ||
                    held_full || (vnew > CNT_W'(MAX_TOTAL));
        // a pair beyond the store still counts but is not kept
        if (!held_full) begin
          ram_we   = 1'b1;
          held_nxt = held_r + HELD_W'(1);
        end
        state_nxt = last_r ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        if (!oval_r || out_tready) begin
          oval_nxt  = 1'b1;
          oexp_nxt  = e_sat;
          oflag_nxt = e_flag;
          held_nxt  = '0;
          gtot_nxt  = '0;
          getot_nxt = '0;
          vtot_nxt  = '0;
          ctot_nxt  = '0;
          stot_nxt  = '0;
          odd_nxt   = 1'b0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = oval_r;
  assign out_tdata  = OUT_DATA_W'(oexp_r);
  assign out_tuser  = oflag_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_EXP) ? CFG_DATA_W'(maxe_r)
                                                    : CFG_DATA_W'(mode_r);

endmodule

`default_nettype wire

/* design/cte_chk.sv */
// Port-level checks for the edge orbit exponent block, bound to the top level.
`default_nettype none

module cte_chk (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            in_tlast,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [cte_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire logic                            out_tuser
);

  import cte_pkg::*;

  // result word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // one pair at a time: busy right after a word is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("pair taken while previous pair in work");

  // an unflagged exponent is never negative
  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> !out_tdata[EXP_W-1])
    else $error("negative exponent not flagged");

  // reset empties the output register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a non-last pair never produces a fresh result next cycle
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast |=> !$rose(out_tvalid))
    else $error("result raised after non-last pair");

endmodule

bind cycle_type_orbit_exponent cte_chk u_cte_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
